[hw/rtl/bsp_pkg.sv]
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types and constants of the bit stream packer.
// ----------------------------------------------------------------------------
package bsp_pkg;

    localparam int POS_W         = 14;
    localparam int CNT_W         = 7;
    localparam int VAL_W         = 64;
    localparam int RD_W          = 32;
    localparam int ST_W          = 2;
    localparam int KIND_W        = 3;
    localparam int CFG_W         = 11;
    localparam int CFG_MAX       = (1 << CFG_W) - 1;
    localparam int CFG_RESET     = 1024;
    localparam int BUF_BYTES_DEF = 1024;
    localparam int MAX_WR_BITS   = 64;
    localparam int MAX_RD_BITS   = 32;
    localparam int IN_W          = 72;
    localparam int OUT_W         = 48;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE  = 3'd0,
        KIND_READ   = 3'd1,
        KIND_SKIP   = 3'd2,
        KIND_PAD    = 3'd3,
        KIND_REWIND = 3'd4
    } t_kind;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_END   = 2'd1,
        ST_COUNT = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

endpackage

[hw/rtl/bsp_ram.sv]
// ----------------------------------------------------------------------------
// bsp_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module bsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/bit_stream_packer.sv]
// ----------------------------------------------------------------------------
// bit_stream_packer
// Bit-granular packer and unpacker over a byte store with a bit position.
// ----------------------------------------------------------------------------
// Input words carry a kind in s_axis_tuser (write, read, skip to byte
// boundary, zero-pad to byte boundary, rewind) and a bit count and write
// value in s_axis_tdata. Every input word gives one output word with the
// read bits, a status and the bit position after the operation.
// The buffer size in bytes is set through i_cfg_wen / i_cfg_wdata; the user
// is to write it only while the block is idle, and the block itself does not
// enforce this; values above BUF_BYTES act as BUF_BYTES. Writes and pads do
// a read-modify-write of each byte touched, reads gather each byte touched;
// the store RAM handles one byte per cycle, pipelined over its registered
// read. The next word is taken the cycle after the result enters the output
// register; a 64-bit write can span nine bytes.
// One item is in work at a time; s_axis_tready is high only when idle.
// Reset clears the position to 0 and the buffer size to 1024; store contents
// are undefined until written. While m_axis_tready is low the output word
// holds, and a finished item waits before entering the output register.
// ----------------------------------------------------------------------------
module bit_stream_packer #(
    parameter int BUF_BYTES = bsp_pkg::BUF_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wen,
    input  logic [bsp_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // num_bits[6:0], write_value[70:7], zero[71]
    input  logic [bsp_pkg::IN_W-1:0]    s_axis_tdata,
    // kind[2:0]
    input  logic [bsp_pkg::KIND_W-1:0]  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // read_value[31:0], status[33:32], position_after[47:34]
    output logic [bsp_pkg::OUT_W-1:0]   m_axis_tdata
);
    import bsp_pkg::*;

    localparam int ADDR_W = $clog2(BUF_BYTES);
    localparam int CAP    = (BUF_BYTES > CFG_MAX) ? CFG_MAX : BUF_BYTES;

    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_buf;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_cur, n_cur;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [VAL_W-1:0]  r_val, n_val;
    logic              r_read, n_read;
    logic [RD_W-1:0]   r_acc, n_acc;
    logic [ST_W-1:0]   r_res_st, n_res_st;
    logic [POS_W-1:0]  r_res_pos, n_res_pos;
    logic              r_p_valid;
    logic [ADDR_W-1:0] r_p_addr;
    logic [7:0]        r_p_mask;
    logic [7:0]        r_p_frag;
    logic [2:0]        r_p_off;
    logic [3:0]        r_p_take;
    logic              r_p_read;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;

    logic              accept, issue, load_out;
    logic [CFG_W-1:0]  eff_bytes;
    logic [POS_W:0]    limit, sum, aligned;
    logic [CNT_W-1:0]  cnt;
    logic [VAL_W-1:0]  wval;
    t_status           a_st;
    logic [POS_W-1:0]  a_pos;
    logic              a_go;
    logic [CNT_W-1:0]  a_cnt;
    logic [VAL_W-1:0]  a_val;
    logic              a_read;

    logic [2:0]        off;
    logic [3:0]        room, take;
    logic [7:0]        mask8, top, frag;
    logic [POS_W-1:0]  cur_byte;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]        rdata, merged, got;

    // control
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = a_go ? S_RUN : S_DONE;
                end
            end
            S_RUN: begin
                if (r_rem == CNT_W'(take)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        issue         = (r_state == S_RUN);
        load_out      = (r_state == S_DONE) && !r_p_valid
                        && (!r_out_valid || m_axis_tready);
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    // decode of a new word
    always_comb begin
        eff_bytes = (r_buf > CFG_W'(CAP)) ? CFG_W'(CAP) : r_buf;
        limit     = {1'b0, eff_bytes, 3'b000};
        cnt       = s_axis_tdata[CNT_W-1:0];
        wval      = s_axis_tdata[CNT_W +: VAL_W];
        sum       = {1'b0, r_pos} + (POS_W+1)'(cnt);
        aligned   = ({1'b0, r_pos} + (POS_W+1)'(7)) & ~(POS_W+1)'(7);
        a_st      = ST_OK;
        a_pos     = r_pos;
        a_go      = 1'b0;
        a_cnt     = cnt;
        a_val     = wval << (CNT_W'(MAX_WR_BITS) - cnt);
        a_read    = 1'b0;
        case (t_kind'(s_axis_tuser))
            KIND_WRITE, KIND_READ: begin
                a_read = (s_axis_tuser == KIND_READ);
                if (cnt > CNT_W'(a_read ? MAX_RD_BITS : MAX_WR_BITS)) begin
                    a_st = ST_COUNT;
                end else if (cnt == '0) begin
                    a_st = ST_OK;
                end else if (sum > limit) begin
                    a_st = ST_END;
                end else begin
                    a_pos = sum[POS_W-1:0];
                    a_go  = 1'b1;
                end
            end
            KIND_SKIP, KIND_PAD: begin
                a_val = '0;
                a_cnt = CNT_W'(aligned - {1'b0, r_pos});
                if (aligned > limit) begin
                    a_st = ST_END;
                end else begin
                    a_pos = aligned[POS_W-1:0];
                    a_go  = (s_axis_tuser == KIND_PAD) && (a_cnt != '0);
                end
            end
            KIND_REWIND: begin
                a_pos = '0;
            end
            default: begin
                a_pos = r_pos;
            end
        endcase
    end

    // byte issue
    always_comb begin
        off      = r_cur[2:0];
        room     = 4'd8 - {1'b0, off};
        take     = (CNT_W'(room) > r_rem) ? r_rem[3:0] : room;
        mask8    = 8'((9'd1 << take) - 9'd1);
        top      = r_val[VAL_W-1 -: 8];
        frag     = (top >> (4'd8 - take)) & mask8;
        cur_byte = r_cur >> 3;
        raddr    = ADDR_W'(cur_byte);
    end

    // merge and gather
    always_comb begin
        merged = (rdata & ~r_p_mask) | r_p_frag;
        got    = (rdata & r_p_mask) >> r_p_off;
    end

    always_comb begin
        n_pos     = r_pos;
        n_cur     = r_cur;
        n_rem     = r_rem;
        n_val     = r_val;
        n_read    = r_read;
        n_acc     = r_acc;
        n_res_st  = r_res_st;
        n_res_pos = r_res_pos;
        if (accept) begin
            n_pos     = a_pos;
            n_cur     = r_pos;
            n_rem     = a_cnt;
            n_val     = a_val;
            n_read    = a_read;
            n_acc     = '0;
            n_res_st  = a_st;
            n_res_pos = a_pos;
        end
        if (issue) begin
            n_cur = r_cur + POS_W'(take);
            n_rem = r_rem - CNT_W'(take);
            n_val = r_val << take;
        end
        if (r_p_valid && r_p_read) begin
            n_acc = (r_acc << r_p_take) | RD_W'(got);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_buf       <= CFG_W'(CFG_RESET);
            r_pos       <= '0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_p_valid <= issue;
            if (i_cfg_wen) begin
                r_buf <= i_cfg_wdata;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_rem     <= n_rem;
        r_val     <= n_val;
        r_read    <= n_read;
        r_acc     <= n_acc;
        r_res_st  <= n_res_st;
        r_res_pos <= n_res_pos;
        r_p_addr  <= raddr;
        r_p_mask  <= mask8 << off;
        r_p_frag  <= frag << off;
        r_p_off   <= off;
        r_p_take  <= take;
        r_p_read  <= r_read;
        if (load_out) begin
            r_out_data <= {r_res_pos, r_res_st, r_acc};
        end
    end

    bsp_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_p_valid && !r_p_read),
        .i_waddr (r_p_addr),
        .i_wdata (merged),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

[hw/rtl/bsp_checker.sv]
// ----------------------------------------------------------------------------
// bsp_checker
// Port-level checks of the bit stream packer, bound to the top level.
// ----------------------------------------------------------------------------
module bsp_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [bsp_pkg::OUT_W-1:0] m_axis_tdata
);
    import bsp_pkg::*;

    logic [ST_W-1:0] st;
    logic [RD_W-1:0] rd;

    assign st = m_axis_tdata[RD_W +: ST_W];
    assign rd = m_axis_tdata[RD_W-1:0];

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output word valid right after reset");

    a_one_item_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again before the item finished");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (st == ST_OK) || ((st == ST_END || st == ST_COUNT) && rd == '0))
        else $error("bad status or read bits on a refused word");

endmodule

bind bit_stream_packer bsp_checker u_bsp_checker (.*);
